### rtl/upkx_pkg.sv
package upkx_pkg;

    localparam int MaxPayloadBytes = 1024;
    localparam logic [15:0] PayloadStart = 16'd42;
    localparam logic [15:0] PayloadEnd = 16'(42 + MaxPayloadBytes);

    localparam logic [1:0] CfgModulus = 2'd0;
    localparam logic [1:0] CfgGenerator = 2'd1;
    localparam logic [1:0] CfgPort = 2'd2;
    localparam logic [1:0] CfgExpLimit = 2'd3;

    localparam logic [1:0] ModePass = 2'd0;
    localparam logic [1:0] ModeXor = 2'd1;
    localparam logic [1:0] ModeNewline = 2'd2;
    localparam logic [1:0] ModeCounted = 2'd3;

    typedef struct packed {
        logic        func;
        logic [7:0]  data_in;
        logic [15:0] frame_length;
        logic        last_in;
        logic [31:0] fresh_random;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_out;
        logic        last_out;
        logic        matched;
        logic [31:0] frame_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RND, ST_PUB, ST_PUB_WAIT, ST_SH, ST_SH_WAIT, ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;       // register the input item, run header logic
        logic rnd_start;  // unused; random mod (m-1) starts with take
        logic pub_start;  // start power for public key
        logic sh_start;   // start power for shared key
        logic finish;     // apply payload decision and build the result
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic need_rnd;
        logic need_pub;
        logic need_sh;
    } sts_t;

endpackage

### rtl/upkx_datapath.sv
module upkx_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  upkx_pkg::in_item_t s_item,
    input  upkx_pkg::cmd_t     cmd,
    output upkx_pkg::sts_t     sts,
    output upkx_pkg::out_item_t res,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import upkx_pkg::*;

    logic [7:0]  mod_reg, gen_reg;
    logic [15:0] port_reg;
    logic [5:0]  elim_reg;
    in_item_t    it_reg;
    logic [15:0] pos_reg;
    logic        ok_reg;
    logic [7:0]  hi_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  priv_reg, part_reg, shk_reg, pub_reg;
    logic        privv_reg, partv_reg, shv_reg;
    logic [31:0] icnt_reg, ecnt_reg;
    logic        need_pub_reg, need_sh_reg, dec_reg;

    // unit: one step per cycle, either restoring division of random or power bits
    logic [1:0]  op_reg;     // 0 idle, 1 mod, 2 power
    logic [5:0]  cnt_reg;
    logic [39:0] rem_reg;    // remainder:dividend shift register
    logic [7:0]  pb_reg, pr_reg;
    logic [5:0]  pe_reg;
    logic        pdst_reg;   // 0 public, 1 shared

    logic [7:0]  m_eff;
    logic [15:0] pair;
    logic        ok_now;
    logic [7:0]  mm1;
    logic [8:0]  div_sh;
    logic [9:0]  trial;
    logic [7:0]  prod_mod;

    logic [1:0]  mode_next;
    out_item_t   res_next;

    assign m_eff = (mod_reg < 8'd2) ? 8'd2 : mod_reg;
    assign mm1 = m_eff - 8'd1;
    assign pair = {hi_reg, s_item.data_in};

    // products are reduced mod m by restoring subtraction, one step per cycle
    logic [15:0] red_reg;
    logic [3:0]  rstep_reg;
    logic [15:0] sub_sh;
    assign sub_sh = {8'd0, m_eff} << rstep_reg;
    assign prod_mod = red_reg[7:0];
    assign div_sh = {rem_reg[39:32], rem_reg[31]};
    assign trial = {1'b0, div_sh} - {2'd0, mm1};

    always_comb begin
        ok_now = ok_reg;
        if (pos_reg == 16'd13 && pair != 16'h0800) ok_now = 1'b0;
        if (pos_reg == 16'd23 && s_item.data_in != 8'd17) ok_now = 1'b0;
        if (pos_reg == 16'd35 && !s_item.func && pair != port_reg) ok_now = 1'b0;
        if (pos_reg == 16'd37 && s_item.func && pair != port_reg) ok_now = 1'b0;
    end

    assign sts.busy = (op_reg != 2'd0);
    assign sts.need_rnd = 1'b0;
    assign sts.need_pub = need_pub_reg && !privv_reg ? 1'b1 : need_pub_reg;
    assign sts.need_sh = need_sh_reg;

    logic egr_setup, ing_setup;
    assign egr_setup = pos_reg == 16'd37 && s_item.func && ok_now
                       && s_item.frame_length >= PayloadStart;
    assign ing_setup = pos_reg == PayloadStart && ok_now && !s_item.func
                       && s_item.frame_length >= PayloadStart + 16'd4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= 8'd23; gen_reg <= 8'd5; port_reg <= 16'd12345; elim_reg <= 6'd32;
            pos_reg <= '0; ok_reg <= 1'b1; hi_reg <= '0; mode_reg <= ModePass;
            privv_reg <= 1'b0; partv_reg <= 1'b0; shv_reg <= 1'b0;
            priv_reg <= '0; part_reg <= '0; shk_reg <= '0; pub_reg <= '0;
            icnt_reg <= '0; ecnt_reg <= '0;
            need_pub_reg <= 1'b0; need_sh_reg <= 1'b0; dec_reg <= 1'b0;
            op_reg <= 2'd0; cnt_reg <= '0; pdst_reg <= 1'b0;
            rstep_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CfgModulus:   mod_reg <= cfg_data[7:0];
                    CfgGenerator: gen_reg <= cfg_data[7:0];
                    CfgPort:      port_reg <= cfg_data;
                    CfgExpLimit:  elim_reg <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (cmd.take) begin
                it_reg <= s_item;
                ok_reg <= ok_now;
                dec_reg <= ok_now;
                if (pos_reg == 16'd12 || pos_reg == 16'd34 || pos_reg == 16'd36)
                    hi_reg <= s_item.data_in;
                need_pub_reg <= egr_setup;
                need_sh_reg <= ing_setup && privv_reg && !shv_reg;
                if (egr_setup && !privv_reg) begin
                    op_reg <= 2'd1; cnt_reg <= 6'd32;
                    rem_reg <= {8'd0, s_item.fresh_random};
                end
                if (ing_setup && !partv_reg) begin
                    part_reg <= s_item.data_in; partv_reg <= 1'b1;
                end
            end
            // shared after public on egress
            if (cmd.pub_start) begin
                op_reg <= 2'd2; pdst_reg <= 1'b0; pb_reg <= gen_reg; pr_reg <= 8'd1;
                pe_reg <= (priv_reg > {2'd0, elim_reg}) ? elim_reg : priv_reg[5:0];
                cnt_reg <= 6'd0; rstep_reg <= 4'd8;
                red_reg <= {8'd0, gen_reg};
                need_pub_reg <= 1'b0;
                need_sh_reg <= partv_reg && !shv_reg;
            end
            if (cmd.sh_start) begin
                op_reg <= 2'd2; pdst_reg <= 1'b1; pb_reg <= part_reg; pr_reg <= 8'd1;
                pe_reg <= (priv_reg > {2'd0, elim_reg}) ? elim_reg : priv_reg[5:0];
                cnt_reg <= 6'd0; rstep_reg <= 4'd8;
                red_reg <= {8'd0, part_reg};
                need_sh_reg <= 1'b0;
            end
            if (op_reg == 2'd1) begin
                // one restoring division bit per cycle, 32 bits then the result
                if (cnt_reg == 6'd0) begin
                    priv_reg <= rem_reg[39:32] + 8'd1; privv_reg <= 1'b1; op_reg <= 2'd0;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                    rem_reg <= {(trial[9] ? div_sh[7:0] : trial[7:0]), rem_reg[30:0], 1'b0};
                end
            end else if (op_reg == 2'd2) begin
                // reduce red_reg (holds base or product) by m, 9 steps
                if (rstep_reg != 4'hF) begin
                    if (red_reg >= sub_sh) red_reg <= red_reg - sub_sh;
                    rstep_reg <= rstep_reg - 4'd1;
                end else if (cnt_reg == 6'd0) begin
                    // base reduced; r = 1 mod m
                    pb_reg <= prod_mod; pr_reg <= (m_eff == 8'd1) ? 8'd0 : 8'd1;
                    if (pe_reg == 6'd0) cnt_reg <= 6'd3;
                    else if (pe_reg[0]) begin
                        red_reg <= {8'd0, prod_mod};
                        rstep_reg <= 4'd8; cnt_reg <= 6'd2;
                    end else begin
                        red_reg <= {8'd0, prod_mod} * {8'd0, prod_mod};
                        rstep_reg <= 4'd8; cnt_reg <= 6'd1;
                    end
                end else if (cnt_reg == 6'd2) begin
                    // finished r*b
                    pr_reg <= prod_mod;
                    red_reg <= {8'd0, pb_reg} * {8'd0, pb_reg}; rstep_reg <= 4'd8;
                    cnt_reg <= 6'd1;
                end else if (cnt_reg == 6'd1) begin
                    // finished b*b, shift exponent
                    pb_reg <= prod_mod;
                    pe_reg <= pe_reg >> 1;
                    if (pe_reg[5:1] == 5'd0) cnt_reg <= 6'd3;
                    else if (pe_reg[1]) begin
                        red_reg <= {8'd0, pr_reg} * {8'd0, prod_mod};
                        rstep_reg <= 4'd8; cnt_reg <= 6'd2;
                    end else begin
                        red_reg <= {8'd0, prod_mod} * {8'd0, prod_mod};
                        rstep_reg <= 4'd8;
                    end
                end else begin
                    if (pdst_reg) begin shk_reg <= pr_reg; shv_reg <= 1'b1; end
                    else pub_reg <= pr_reg;
                    op_reg <= 2'd0;
                end
            end
            if (cmd.finish) begin
                if (it_reg.last_in) begin
                    pos_reg <= '0; ok_reg <= 1'b1; hi_reg <= '0; mode_reg <= ModePass;
                    if (mode_next != ModePass) begin
                        if (it_reg.func) ecnt_reg <= ecnt_reg + 32'd1;
                        else icnt_reg <= icnt_reg + 32'd1;
                    end
                end else begin
                    mode_reg <= mode_next;
                    if (pos_reg != 16'hFFFF) pos_reg <= pos_reg + 16'd1;
                end
                res <= res_next;
            end
        end
    end

    always_comb begin
        mode_next = mode_reg;
        res_next.data_out = it_reg.data_in;
        res_next.last_out = it_reg.last_in;
        if (pos_reg == PayloadStart && dec_reg
            && it_reg.frame_length >= PayloadStart + 16'd4) begin
            if (!it_reg.func) mode_next = shv_reg ? ModeXor : ModeCounted;
            else if (it_reg.data_in == 8'h20) begin
                res_next.data_out = pub_reg; mode_next = ModeNewline;
            end else if (shv_reg) mode_next = ModeXor;
        end else if (mode_reg == ModeNewline) begin
            res_next.data_out = 8'h0A; mode_next = ModeCounted;
        end
        if (mode_next == ModeXor && pos_reg >= PayloadStart && pos_reg < PayloadEnd
            && pos_reg < it_reg.frame_length)
            res_next.data_out = it_reg.data_in ^ shk_reg;
        res_next.matched = it_reg.last_in && mode_next != ModePass;
        res_next.frame_count = '0;
        if (it_reg.last_in) begin
            if (it_reg.func) res_next.frame_count = ecnt_reg + 32'(mode_next != ModePass);
            else res_next.frame_count = icnt_reg + 32'(mode_next != ModePass);
        end
    end
endmodule

### rtl/upkx_ctrl.sv
module upkx_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output upkx_pkg::cmd_t cmd,
    input  upkx_pkg::sts_t sts
);
    import upkx_pkg::*;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        mv_next = mv_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    state_next = ST_RND;
                end
            end
            ST_RND: if (!sts.busy) begin
                if (sts.need_pub) begin
                    cmd.pub_start = 1'b1; state_next = ST_PUB_WAIT;
                end else if (sts.need_sh) begin
                    cmd.sh_start = 1'b1; state_next = ST_SH_WAIT;
                end else state_next = ST_EMIT;
            end
            ST_PUB_WAIT: if (!sts.busy) state_next = ST_RND;
            ST_SH_WAIT: if (!sts.busy) state_next = ST_RND;
            ST_EMIT: if (!mv_reg || m_ready) begin
                cmd.finish = 1'b1;
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

### rtl/udp_payload_key_exchange_xor.sv
// Channel | valid   | ready   | payload
// input   | s_valid | s_ready | s_item  (in_item_t)
// result  | m_valid | m_ready | m_item  (out_item_t)
// config  | cfg_we  | -       | cfg_index, cfg_data
//
// An ordinary byte goes through accept, check, then emit into the output register.
// Key setup runs one shared arithmetic unit: random mod (m-1) by restoring division,
// each modular power by square-and-multiply with products reduced by subtraction.
// aresetn is synchronous, active low; it restores register defaults and clears keys.
// A stalled result holds in m_item; the next item is taken while it waits.
module udp_payload_key_exchange_xor (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  upkx_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output upkx_pkg::out_item_t  m_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import upkx_pkg::*;

    cmd_t cmd;
    sts_t sts;

    upkx_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    upkx_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_item), .cmd(cmd), .sts(sts),
        .res(m_item), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // a start command only while the unit is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pub_start || cmd.sh_start) |-> !sts.busy) else $error("unit busy");
    // result register loads only when free or taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid || m_ready)) else $error("result overwrite");
    // input taken only when ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> s_ready && s_valid) else $error("bad take");
endmodule

### test/udp_payload_key_exchange_xor_tb.sv
module udp_payload_key_exchange_xor_tb;
    import upkx_pkg::*;

    // Tracks expected bytes out of the key exchange / XOR block.
    class frame_cipher_sb;
        bit [7:0]  modulus, gen_base, exp_lim;
        bit [15:0] port_sel;
        bit [15:0] pos;
        bit        hdr_ok;
        bit [7:0]  hi_byte;
        bit [1:0]  mode;
        bit [7:0]  priv, partner, shared, pub;
        bit        priv_v, partner_v, shared_v;
        bit [31:0] in_cnt, eg_cnt;
        out_item_t pending[$];
        int        errors;

        function void clear();
            modulus = 23; gen_base = 5; port_sel = 12345; exp_lim = 32;
            pos = 0; hdr_ok = 1; hi_byte = 0; mode = ModePass;
            priv = 0; partner = 0; shared = 0; pub = 0;
            priv_v = 0; partner_v = 0; shared_v = 0;
            in_cnt = 0; eg_cnt = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CfgModulus:   modulus = val[7:0];
                CfgGenerator: gen_base = val[7:0];
                CfgPort:      port_sel = val;
                CfgExpLimit:  exp_lim = {2'b0, val[5:0]};
                default: ;
            endcase
        endfunction

        function int unsigned eff_mod();
            return (modulus < 2) ? 2 : modulus;
        endfunction

        // exact square-and-multiply, exponent clamped to the limit
        function bit [7:0] mod_power(bit [7:0] base, bit [7:0] e_raw);
            int unsigned m, e, b, r;
            m = eff_mod();
            e = (e_raw > exp_lim) ? exp_lim : e_raw;
            b = base % m;
            r = 1 % m;
            while (e != 0) begin
                if (e & 1) r = (r * b) % m;
                b = (b * b) % m;
                e = e >> 1;
            end
            return r[7:0];
        endfunction

        function void note_input(in_item_t it);
            out_item_t   exp_o;
            bit          egress;
            bit [15:0]   pair;
            int unsigned p, flen;
            egress = it.func;
            p = pos;
            flen = it.frame_length;
            pair = {hi_byte, it.data_in};
            exp_o = '0;
            exp_o.data_out = it.data_in;
            if (p == 12 || p == 34 || p == 36) hi_byte = it.data_in;
            if (p == 13 && pair != 16'h0800) hdr_ok = 0;
            if (p == 23 && it.data_in != 8'd17) hdr_ok = 0;
            if (p == 35 && !egress && pair != port_sel) hdr_ok = 0;
            if (p == 37 && egress && pair != port_sel) hdr_ok = 0;

            // egress key setup at the last port byte
            if (p == 37 && egress && hdr_ok && flen >= 42) begin
                if (!priv_v) begin
                    priv = 8'(it.fresh_random % (eff_mod() - 1) + 1);
                    priv_v = 1;
                end
                pub = mod_power(gen_base, priv);
                if (partner_v && !shared_v) begin
                    shared = mod_power(partner, priv);
                    shared_v = 1;
                end
            end

            // payload decision at the first payload byte
            if (p == 42 && hdr_ok && flen >= 46) begin
                if (!egress) begin
                    if (!partner_v) begin
                        partner = it.data_in;
                        partner_v = 1;
                    end
                    if (priv_v && !shared_v) begin
                        shared = mod_power(partner, priv);
                        shared_v = 1;
                    end
                    mode = shared_v ? ModeXor : ModeCounted;
                end else if (it.data_in == 8'h20) begin
                    exp_o.data_out = pub;
                    mode = ModeNewline;
                end else if (shared_v) begin
                    mode = ModeXor;
                end
            end else if (mode == ModeNewline) begin
                exp_o.data_out = 8'h0A;
                mode = ModeCounted;
            end

            if (mode == ModeXor && p >= 42 && p < 42 + MaxPayloadBytes && p < flen)
                exp_o.data_out = it.data_in ^ shared;

            exp_o.last_out = it.last_in;
            if (it.last_in) begin
                if (mode != ModePass) begin
                    if (egress) eg_cnt++;
                    else in_cnt++;
                end
                exp_o.matched = (mode != ModePass);
                exp_o.frame_count = egress ? eg_cnt : in_cnt;
                pos = 0; hdr_ok = 1; hi_byte = 0; mode = ModePass;
            end else if (pos != 16'hFFFF) begin
                pos++;
            end
            pending.push_back(exp_o);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.data_out !== e.data_out) begin
                $error("data_out exp %h got %h", e.data_out, got.data_out);
                errors++;
            end
            if (got.last_out !== e.last_out) begin
                $error("last_out exp %b got %b", e.last_out, got.last_out);
                errors++;
            end
            if (got.matched !== e.matched) begin
                $error("matched exp %b got %b", e.matched, got.matched);
                errors++;
            end
            if (got.frame_count !== e.frame_count) begin
                $error("frame_count exp %0d got %0d", e.frame_count, got.frame_count);
                errors++;
            end
        endfunction
    endclass

    localparam int CycleLimit = 1500000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    frame_cipher_sb sb;
    int  cycles;
    int  sent;
    bit  no_idle;
    int  stall_left;

    udp_payload_key_exchange_xor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hang or lost result ends here
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, none in the final phase.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 0;
        end else if (no_idle) begin
            m_ready = 1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready = 0;
        end else begin
            m_ready = 1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 0;
        sb.set_reg(idx, val);
    endtask

    // Drain every expected item, then let key arithmetic settle.
    task automatic drain();
        s_valid = 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // One item; valid stays high across back-to-back items.
    task automatic send_item(in_item_t it);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_valid = 0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid = 1;
        s_item = it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        sent++;
        @(negedge aclk);
    endtask

    // Builds a UDP frame; corrupt picks one header check to break.
    task automatic send_frame(bit eg, int len, bit [15:0] flen, int corrupt, bit [7:0] first);
        in_item_t it;
        bit [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            case (i)
                12: b = 8'h08;
                13: b = 8'h00;
                23: b = 8'd17;
                34: if (!eg) b = sb.port_sel[15:8];
                35: if (!eg) b = sb.port_sel[7:0];
                36: if (eg) b = sb.port_sel[15:8];
                37: if (eg) b = sb.port_sel[7:0];
                42: b = first;
                default: ;
            endcase
            if ((corrupt == 1 && i == 12) || (corrupt == 2 && i == 23) ||
                (corrupt == 3 && (i == 35 || i == 37))) b = b ^ (8'h1 << $urandom_range(0, 7));
            it.func = eg;
            it.data_in = b;
            it.frame_length = flen;
            it.last_in = (i == len - 1);
            it.fresh_random = $urandom;
            send_item(it);
        end
    endtask

    task automatic random_frame(bit big);
        bit        eg;
        int        len;
        bit [15:0] flen;
        int        corrupt;
        bit [7:0]  first;
        eg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1:    len = $urandom_range(1, 45);
            default: len = $urandom_range(46, 90);
        endcase
        if (big) len = $urandom_range(1067, 1080);
        flen = 16'(len);
        case ($urandom_range(0, 11))
            0: flen = 0;
            1: flen = 16'hFFFF;
            2: flen = 16'($urandom_range(40, 47));
            3: flen = 16'($urandom);
            default: ;
        endcase
        corrupt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        first = ($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(0, 255));
        send_frame(eg, len, flen, corrupt, first);
    endtask

    initial begin
        in_item_t it;
        int       phase;
        sb = new();
        sb.clear();
        cycles = 0; sent = 0; no_idle = 0; stall_left = 0;
        s_valid = 0; s_item = '0; m_ready = 0;
        cfg_we = 0; cfg_index = CfgModulus; cfg_data = '0;
        aresetn = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1;

        // Directed: field extremes on lone bytes, each one ending a frame.
        for (int i = 0; i < 8; i++) begin
            it.func = i[0];
            it.data_in = i[1] ? 8'hFF : 8'h00;
            it.frame_length = i[2] ? 16'hFFFF : 16'h0000;
            it.last_in = 1;
            it.fresh_random = i[1] ? 32'hFFFF_FFFF : 32'h0;
            send_item(it);
        end
        // egress frame first: private key from a random value, then a space
        send_frame(1, 46, 46, 0, 8'h20);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CfgModulus, 16'd2);
                    write_reg(CfgGenerator, 16'd1);
                    write_reg(CfgPort, 16'd0);
                    write_reg(CfgExpLimit, 16'd1);
                end
                1: begin
                    write_reg(CfgModulus, 16'd255);
                    write_reg(CfgGenerator, 16'd255);
                    write_reg(CfgPort, 16'hFFFF);
                    write_reg(CfgExpLimit, 16'd63);
                end
                2: begin
                    write_reg(CfgModulus, 16'd0);
                    write_reg(CfgExpLimit, 16'd0);
                end
                3: begin
                    write_reg(CfgModulus, 16'd1);
                    write_reg(CfgGenerator, 16'($urandom_range(1, 255)));
                    write_reg(CfgPort, 16'($urandom));
                end
                default: begin
                    write_reg(CfgModulus, 16'($urandom_range(2, 255)));
                    write_reg(CfgGenerator, 16'($urandom_range(1, 255)));
                    write_reg(CfgPort, 16'd12345);
                    write_reg(CfgExpLimit, 16'($urandom_range(1, 63)));
                end
            endcase
            if (phase == 5) no_idle = 1;
            if (phase == 1) random_frame(1);
            while (sent < 100 + 50 * phase + (phase >= 1 ? 1080 : 0))
                random_frame(0);
            drain();
        end

        s_valid = 0;
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

### udp_payload_key_exchange_xor.f
rtl/upkx_pkg.sv
rtl/upkx_datapath.sv
rtl/upkx_ctrl.sv
rtl/udp_payload_key_exchange_xor.sv
test/udp_payload_key_exchange_xor_tb.sv
